// ----- rtl/spa_pkg.sv -----
// Shared types and constants of the slot pool allocator.
// Used by spa_ctrl, spa_datapath and slot_pool_allocator_top; depends on nothing.
package spa_pkg;

  localparam int unsigned POOL_SLOTS = 1024;
  localparam int unsigned SLOT_W     = 11;
  localparam int unsigned IDX_W      = $clog2(POOL_SLOTS);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned DSZ_W      = 8;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned PROD_W     = SLOT_W + DSZ_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = ADDR_W;

  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(POOL_SLOTS);

  // request codes
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd2;
  localparam logic [1:0] STAT_INVALID   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESC_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 2'd2;

  localparam logic [SLOT_W-1:0] CAPACITY_RST  = '0;
  localparam logic [DSZ_W-1:0]  DESC_SIZE_RST = 8'd32;
  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = '0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mul;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/spa_ctrl.sv -----
// Sequencer of the slot pool allocator: takes a request beat and steps it
// through execute, multiply and result load. Depends on spa_pkg.
module spa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  spa_pkg::stat_t stat_i,
  output spa_pkg::cmd_t  cmd_o
);

  spa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spa_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = spa_pkg::ST_EXEC;
      end
      spa_pkg::ST_EXEC: state_d = spa_pkg::ST_MUL;
      spa_pkg::ST_MUL:  state_d = spa_pkg::ST_DONE;
      spa_pkg::ST_DONE: begin
        // hold until the output register can take the result
        if (stat_i.out_free) state_d = spa_pkg::ST_IDLE;
      end
      default: state_d = spa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o         = '0;
    unique case (state_q)
      spa_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      spa_pkg::ST_EXEC: cmd_o.exec = 1'b1;
      spa_pkg::ST_MUL:  cmd_o.mul  = 1'b1;
      spa_pkg::ST_DONE: cmd_o.load = stat_i.out_free;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == spa_pkg::ST_EXEC))
    else $error("accepted beat did not start execution");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spa_pkg::ST_DONE && !stat_i.out_free) |=> (state_q == spa_pkg::ST_DONE))
    else $error("result dropped while output register busy");
`endif

endmodule

// ----- rtl/spa_datapath.sv -----
// Datapath of the slot pool allocator: configuration registers, free stack
// memory, bump pointer, handle multiply-add and output register. Depends on spa_pkg.
module spa_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [spa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [spa_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [1:0]                         mode_i,
  input  logic [spa_pkg::SLOT_W-1:0]         slot_i,
  input  spa_pkg::cmd_t                      cmd_i,
  output spa_pkg::stat_t                     stat_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [spa_pkg::SLOT_W-1:0]         slot_out_o,
  output logic [spa_pkg::ADDR_W-1:0]         handle_o,
  output logic [1:0]                         status_o,
  output logic                               first_exhaustion_o
);

  localparam int unsigned SLOT_W = spa_pkg::SLOT_W;
  localparam int unsigned IDX_W  = spa_pkg::IDX_W;
  localparam int unsigned CNT_W  = spa_pkg::CNT_W;
  localparam int unsigned ADDR_W = spa_pkg::ADDR_W;
  localparam int unsigned PROD_W = spa_pkg::PROD_W;

  // configuration
  logic [SLOT_W-1:0]        capacity_q;
  logic [spa_pkg::DSZ_W-1:0] desc_size_q;
  logic [ADDR_W-1:0]        heap_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= spa_pkg::CAPACITY_RST;
      desc_size_q <= spa_pkg::DESC_SIZE_RST;
      heap_base_q <= spa_pkg::HEAP_BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spa_pkg::CFG_CAPACITY:  capacity_q  <= cfg_data_i[SLOT_W-1:0];
        spa_pkg::CFG_DESC_SIZE: desc_size_q <= cfg_data_i[spa_pkg::DSZ_W-1:0];
        spa_pkg::CFG_HEAP_BASE: heap_base_q <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  logic [1:0]        mode_q;
  logic [SLOT_W-1:0] slot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      slot_q <= slot_i;
    end
  end

  // pool state
  logic [CNT_W-1:0]  stack_count_q, stack_count_d;
  logic [SLOT_W-1:0] next_unused_q, next_unused_d;
  logic              warned_q, warned_d;

  // execute step results
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic [1:0]        res_status_q, res_status_d;
  logic              res_first_q, res_first_d;
  logic              has_handle_q, has_handle_d;
  logic              pop_q, pop_d;
  logic              push_en;
  logic [SLOT_W-1:0] cap;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  count_dec;

  assign cap       = (capacity_q > spa_pkg::NO_SLOT) ? spa_pkg::NO_SLOT : capacity_q;
  assign count_dec = stack_count_q - CNT_W'(1);
  assign wr_addr   = stack_count_q[IDX_W-1:0];
  assign rd_addr   = count_dec[IDX_W-1:0];

  always_comb begin
    stack_count_d = stack_count_q;
    next_unused_d = next_unused_q;
    warned_d      = warned_q;
    res_slot_d    = spa_pkg::NO_SLOT;
    res_status_d  = spa_pkg::STAT_OK;
    res_first_d   = 1'b0;
    has_handle_d  = 1'b0;
    pop_d         = 1'b0;
    push_en       = 1'b0;
    if (cmd_i.exec) begin
      case (mode_q)
        spa_pkg::MODE_ALLOC: begin
          if (stack_count_q != '0) begin
            stack_count_d = count_dec;
            pop_d         = 1'b1;
            has_handle_d  = 1'b1;
          end else if (next_unused_q < cap) begin
            res_slot_d    = next_unused_q;
            next_unused_d = next_unused_q + SLOT_W'(1);
            has_handle_d  = 1'b1;
          end else begin
            res_status_d = spa_pkg::STAT_EXHAUSTED;
            res_first_d  = !warned_q;
            warned_d     = 1'b1;
          end
        end
        spa_pkg::MODE_FREE: begin
          if (slot_q >= spa_pkg::NO_SLOT) begin
            res_status_d = spa_pkg::STAT_INVALID;
          end else if (stack_count_q >= CNT_W'(spa_pkg::POOL_SLOTS)) begin
            res_status_d = spa_pkg::STAT_OVERFLOW;
          end else begin
            push_en       = 1'b1;
            stack_count_d = stack_count_q + CNT_W'(1);
          end
        end
        spa_pkg::MODE_QUERY: begin
          res_slot_d   = slot_q;
          has_handle_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_count_q <= '0;
      next_unused_q <= '0;
      warned_q      <= 1'b0;
    end else begin
      stack_count_q <= stack_count_d;
      next_unused_q <= next_unused_d;
      warned_q      <= warned_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_status_q <= res_status_d;
      res_first_q  <= res_first_d;
      has_handle_q <= has_handle_d;
      pop_q        <= pop_d;
    end
  end

  // free stack memory, registered read
  logic [IDX_W-1:0] stack_mem [spa_pkg::POOL_SLOTS];
  logic [IDX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (push_en) stack_mem[wr_addr] <= slot_q[IDX_W-1:0];
    if (pop_d)   rd_data_q <= stack_mem[rd_addr];
  end

  // multiply step: the popped slot arrives from memory here
  logic [SLOT_W-1:0] sel_slot;
  logic [PROD_W-1:0] prod_q;

  assign sel_slot = pop_q ? SLOT_W'(rd_data_q) : res_slot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_slot_q <= res_slot_d;
    end else if (cmd_i.mul) begin
      res_slot_q <= sel_slot;
      prod_q     <= PROD_W'(sel_slot) * PROD_W'(desc_size_q);
    end
  end

  // output register
  logic              out_valid_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [ADDR_W-1:0] out_handle_q;
  logic [1:0]        out_status_q;
  logic              out_first_q;

  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_slot_q   <= res_slot_q;
      out_handle_q <= has_handle_q ? heap_base_q + ADDR_W'(prod_q) : '0;
      out_status_q <= res_status_q;
      out_first_q  <= res_first_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign slot_out_o         = out_slot_q;
  assign handle_o           = out_handle_q;
  assign status_o           = out_status_q;
  assign first_exhaustion_o = out_first_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_count_q <= CNT_W'(spa_pkg::POOL_SLOTS))
    else $error("free stack count beyond pool size");

  a_warn_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warned_q |=> warned_q)
    else $error("exhaustion flag cleared without reset");

  a_exh_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == spa_pkg::STAT_EXHAUSTED)
      |-> (out_slot_q == spa_pkg::NO_SLOT && out_handle_q == '0))
    else $error("exhausted result carries a slot or handle");
`endif

endmodule

// ----- rtl/slot_pool_allocator_top.sv -----
// Slot pool allocator: LIFO free stack of 1024 slots plus a bump pointer.
// One request at a time: a new beat is accepted only once the last
// result is loaded (steps: accept, stack access, multiply, add).
// Reset clears stack count, bump pointer and exhaustion flag at once; the
// stack memory is not cleared, and configuration returns to its reset values.
module slot_pool_allocator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     mode_i,
  input  logic [spa_pkg::SLOT_W-1:0]     slot_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [spa_pkg::SLOT_W-1:0]     slot_out_o,
  output logic [spa_pkg::ADDR_W-1:0]     handle_o,
  output logic [1:0]                     status_o,
  output logic                           first_exhaustion_o
);

  spa_pkg::cmd_t  cmd;
  spa_pkg::stat_t stat;

  spa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spa_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .mode_i             (mode_i),
    .slot_i             (slot_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .slot_out_o         (slot_out_o),
    .handle_o           (handle_o),
    .status_o           (status_o),
    .first_exhaustion_o (first_exhaustion_o)
  );

endmodule
